// File: src/rebd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rebd_pkg
// Shared constants and the command type passed from the decode front end to
// the byte packer of the run-length decoder.
// ----------------------------------------------------------------------------
package rebd_pkg;

   // bytes per output word
   localparam int unsigned WordBytes = 8;

   // escape marker and short-run limit of the compressed format
   localparam logic [7:0] EscByte       = 8'hFF;
   localparam logic [7:0] ShortRunLimit = 8'd3;

   // one decoded run, or an end-of-stream flush with no bytes
   typedef struct packed {
      logic       has_run;   // value is repeated count_m1 + 1 times
      logic [7:0] value;     // byte to repeat
      logic [7:0] count_m1;  // repeat count minus one
      logic       eos;       // flush the partial word after the run
      logic       trunc;     // stream ended inside an escape
   } rebd_cmd_type;

endpackage
`default_nettype wire

// File: src/rebd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rebd_if
// Valid/ready channels of the run-length decoder: compressed bytes in,
// packed words out.
// ----------------------------------------------------------------------------
interface rebd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface rebd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_word;
   logic [3:0]  valid_bytes;
   logic        last;
   logic        truncated;

   modport source (output valid, output out_word, output valid_bytes,
                   output last, output truncated, input ready);
   modport sink   (input valid, input out_word, input valid_bytes,
                   input last, input truncated, output ready);
endinterface
`default_nettype wire

// File: src/rebd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rebd_front
// Decode front end: tracks the escape sequence across input beats and turns
// each beat into at most one run command for the packer.
// ----------------------------------------------------------------------------
module rebd_front (
   input  logic                  clock,
   input  logic                  reset,
   rebd_req_if.sink              req,
   input  logic                  push_ready,
   output logic                  push_valid,
   output rebd_pkg::rebd_cmd_type push_cmd
);
   import rebd_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_COUNT = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;

   logic [1:0] phase_ff, phase_in, phase_dec;
   logic [7:0] run_len_ff, run_len_in, run_dec;
   logic       accept;

   // a beat is taken whenever the command queue has room
   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   // classify the beat against the escape sequence
   always_comb begin
      push_cmd.has_run  = 1'b0;
      push_cmd.value    = req.in_byte;
      push_cmd.count_m1 = 8'd0;
      push_cmd.eos      = req.end_of_stream;
      phase_dec         = PH_IDLE;
      run_dec           = run_len_ff;
      case (phase_ff)
         PH_COUNT: begin
            if (req.in_byte < ShortRunLimit) begin
               push_cmd.has_run  = 1'b1;
               push_cmd.value    = EscByte;
               push_cmd.count_m1 = req.in_byte;
            end else begin
               run_dec   = req.in_byte;
               phase_dec = PH_VALUE;
            end
         end
         PH_VALUE: begin
            push_cmd.has_run  = 1'b1;
            push_cmd.count_m1 = run_len_ff;
            run_dec           = 8'd0;
         end
         default: begin
            if (req.in_byte == EscByte) begin
               phase_dec = PH_COUNT;
            end else begin
               push_cmd.has_run = 1'b1;
            end
         end
      endcase
      push_cmd.trunc = (phase_dec != PH_IDLE);
   end

   assign push_valid = accept && (push_cmd.has_run || push_cmd.eos);

   // next state, back to idle at end of stream
   always_comb begin
      phase_in   = phase_ff;
      run_len_in = run_len_ff;
      if (accept) begin
         if (req.end_of_stream) begin
            phase_in   = PH_IDLE;
            run_len_in = 8'd0;
         end else begin
            phase_in   = phase_dec;
            run_len_in = run_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         run_len_ff <= 8'd0;
      end else begin
         phase_ff   <= phase_in;
         run_len_ff <= run_len_in;
      end
   end

   // end of stream always leaves the decoder clean
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.end_of_stream |=> phase_ff == PH_IDLE && run_len_ff == 8'd0)
      else $error("decode state not cleared after end of stream");

   // a pending long run always holds a count of at least the limit
   a_long_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VALUE |-> run_len_ff >= ShortRunLimit)
      else $error("long run pending with a short count");

endmodule
`default_nettype wire

// File: src/rebd_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rebd_cmd_fifo
// Two-entry command queue between the decode front end and the packer.
// ----------------------------------------------------------------------------
module rebd_cmd_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  rebd_pkg::rebd_cmd_type push_cmd,
   output logic                  push_ready,
   input  logic                  pop,
   output logic                  head_valid,
   output rebd_pkg::rebd_cmd_type head_cmd
);
   import rebd_pkg::*;

   rebd_cmd_type entry_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule
`default_nettype wire

// File: src/rebd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rebd_back
// Byte packer: expands run commands into the word buffer, up to a full word
// per cycle unless a full word waits on rsp, and drives the output register.
// ----------------------------------------------------------------------------
module rebd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  rebd_pkg::rebd_cmd_type head_cmd,
   output logic                  pop,
   rebd_rsp_if.source            rsp
);
   import rebd_pkg::*;

   logic        started_ff, started_in;
   logic [8:0]  rem_ff, rem_in;
   logic [63:0] buffer_ff, buffer_in;
   logic [2:0]  fill_ff, fill_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] word_ff;
   logic [3:0]  vbytes_ff;
   logic        last_ff, trunc_ff;

   logic [8:0]  rem_eff, rem_left;
   logic [3:0]  room, take, new_fill;
   logic [63:0] merged;
   logic        out_free, emit;
   logic [63:0] emit_word;
   logic [3:0]  emit_vbytes;
   logic        emit_last, emit_trunc;

   assign out_free = !rsp_valid_ff || rsp.ready;

   // bytes still owed by the command at the head of the queue
   always_comb begin
      if (started_ff) begin
         rem_eff = rem_ff;
      end else if (head_cmd.has_run) begin
         rem_eff = {1'b0, head_cmd.count_m1} + 9'd1;
      end else begin
         rem_eff = 9'd0;
      end
   end

   // how many bytes fit this cycle
   assign room     = 4'(WordBytes) - {1'b0, fill_ff};
   assign take     = (rem_eff > {5'd0, room}) ? room : rem_eff[3:0];
   assign new_fill = {1'b0, fill_ff} + take;
   assign rem_left = rem_eff - {5'd0, take};

   // write the run value into lanes fill .. new_fill-1
   always_comb begin
      merged = buffer_ff;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) >= {1'b0, fill_ff} && 4'(i) < new_fill) begin
            merged[8*i +: 8] = head_cmd.value;
         end
      end
   end

   // packer sequencing
   always_comb begin
      started_in  = started_ff;
      rem_in      = rem_ff;
      buffer_in   = buffer_ff;
      fill_in     = fill_ff;
      pop         = 1'b0;
      emit        = 1'b0;
      emit_word   = buffer_ff;
      emit_vbytes = {1'b0, fill_ff};
      emit_last   = 1'b0;
      emit_trunc  = 1'b0;
      if (head_valid) begin
         if (rem_eff != 9'd0) begin
            if (new_fill == 4'(WordBytes)) begin
               // full word goes out
               if (out_free) begin
                  emit        = 1'b1;
                  emit_word   = merged;
                  emit_vbytes = 4'(WordBytes);
                  buffer_in   = 64'd0;
                  fill_in     = 3'd0;
                  rem_in      = rem_left;
                  started_in  = 1'b1;
                  if (rem_left == 9'd0 && !head_cmd.eos) begin
                     pop        = 1'b1;
                     started_in = 1'b0;
                  end
               end
            end else begin
               // run ends inside the word
               buffer_in = merged;
               fill_in   = new_fill[2:0];
               rem_in    = 9'd0;
               if (head_cmd.eos) begin
                  started_in = 1'b1;
               end else begin
                  pop        = 1'b1;
                  started_in = 1'b0;
               end
            end
         end else if (out_free) begin
            // end-of-stream flush of the partial word
            emit       = 1'b1;
            emit_last  = 1'b1;
            emit_trunc = head_cmd.trunc;
            buffer_in  = 64'd0;
            fill_in    = 3'd0;
            pop        = 1'b1;
            started_in = 1'b0;
         end
      end
   end

   // output register
   assign rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         buffer_ff    <= 64'd0;
         fill_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         buffer_ff    <= buffer_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (emit) begin
         word_ff   <= emit_word;
         vbytes_ff <= emit_vbytes;
         last_ff   <= emit_last;
         trunc_ff  <= emit_trunc;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_word    = word_ff;
   assign rsp.valid_bytes = vbytes_ff;
   assign rsp.last        = last_ff;
   assign rsp.truncated   = trunc_ff;

   // a run in progress keeps its command at the queue head
   a_started_head: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> head_valid)
      else $error("packer mid-run with an empty queue");

   // only the final word of a stream may be partial
   a_full_unless_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !last_ff |-> vbytes_ff == 4'(WordBytes) && !trunc_ff)
      else $error("partial or truncated word without last");

endmodule
`default_nettype wire

// File: src/rle_escape_byte_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_escape_byte_decoder_unit
// Run-length decoder with an 0xFF escape, packing bytes into 64-bit words.
// ----------------------------------------------------------------------------
// usage
//   req: one compressed byte per beat, end_of_stream on the final byte.
//   rsp: one packed word per beat, first decoded byte in bits 7:0,
//        valid_bytes counts bytes from the low end, last marks the final
//        word of a stream, truncated flags a stream cut inside an escape.
//   the packer writes a literal into the word buffer and expands a run
//   into each word that it touches in turn; end of stream adds a flush
//   word marked last.
//   the beat that completes a word is written into the command queue, and
//   the packer then puts the word into the output register for rsp.
//   escape bytes and long-run counts only update the decoder state.
//   the front end and packer are split by a two-entry command queue, so
//   the front keeps taking bytes while a long run is being expanded
//   until the queue fills; req.ready then drops.
//   when rsp is stalled the output register holds its word, the packer
//   waits, and the stall reaches req through the queue.
//   reset (synchronous) clears the decoder, the queue and the buffer.
// ----------------------------------------------------------------------------
module rle_escape_byte_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   rebd_req_if.sink   req,
   rebd_rsp_if.source rsp
);
   import rebd_pkg::*;

   logic         push_valid, push_ready;
   rebd_cmd_type push_cmd;
   logic         pop, head_valid;
   rebd_cmd_type head_cmd;

   // escape decode
   rebd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // command queue
   rebd_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // byte packer and output register
   rebd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule
`default_nettype wire
